// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

  localparam int KEY_W    = 55;
  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;

  localparam int TABLE_BITS_DEFAULT = 10;

  // request action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_FIND   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_t;

endpackage

// ===== rtl/lpht_if.sv =====
interface lpht_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [lpht_pkg::KEY_W-1:0]    key;
  logic [lpht_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lpht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::STATUS_W-1:0] status;
  logic [lpht_pkg::VALUE_W-1:0]  found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

// ===== rtl/lpht_slot_ram.sv =====
module lpht_slot_ram #(
  parameter int ADDR_W = lpht_pkg::TABLE_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  lpht_pkg::slot_t     wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output lpht_pkg::slot_t     rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  lpht_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/linear_probe_hash_table_unit.sv =====
// Open-addressing hash table with linear probing: maps a 55-bit key to a
// 31-bit value in 2^TABLE_BITS slots held in one single-port-read,
// single-port-write memory. After reset the block runs a clearing pass over
// all 2^TABLE_BITS slots, one slot per cycle, and accepts no request until it
// ends. A request is taken only while the block is idle. Each probe is a
// memory read, then a key compare and pointer step in the shared compare
// unit; a request occupies the block until its result is loaded into the
// output register, which waits while that register is still occupied; at
// most 2^TABLE_BITS slots are probed. Inserts store at the first empty slot
// from the key's home slot (its low TABLE_BITS bits) and never merge equal
// keys; finds return the first match in probe order. An insert into a full
// table reports full and is dropped; a find that wraps reports not found.
module linear_probe_hash_table_unit #(
  parameter int TABLE_BITS = lpht_pkg::TABLE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  lpht_req_if.sink   req,
  lpht_rsp_if.source rsp
);

  lpht_pkg::state_t state, state_next;

  // clearing pass pointer
  logic [TABLE_BITS-1:0] clr_addr;
  logic                  clr_last;

  // captured request
  logic                          action;
  logic [lpht_pkg::KEY_W-1:0]    key;
  logic [lpht_pkg::VALUE_W-1:0]  value;
  logic [TABLE_BITS-1:0]         home;
  logic [TABLE_BITS-1:0]         pos;

  // shared compare and pointer step
  logic [TABLE_BITS-1:0] pos_inc;
  logic                  wrapped;
  logic                  hit;

  // slot memory
  logic                  ram_we;
  logic [TABLE_BITS-1:0] ram_waddr;
  lpht_pkg::slot_t       ram_wdata;
  logic                  ram_re;
  lpht_pkg::slot_t       ram_rdata;

  // result path
  logic                           out_free;
  logic                           finish;
  logic                           load_out;
  logic                           accept;
  logic [lpht_pkg::STATUS_W-1:0]  res_status;
  logic [lpht_pkg::VALUE_W-1:0]   res_value;

  lpht_slot_ram #(
    .ADDR_W(TABLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  assign clr_last = (clr_addr == {TABLE_BITS{1'b1}});
  assign pos_inc  = pos + {{(TABLE_BITS-1){1'b0}}, 1'b1};
  // one full pass done once the next slot would be the home slot again
  assign wrapped  = (pos_inc == home);
  assign hit      = ram_rdata.valid && (ram_rdata.key == key);
  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;

  // probe outcome for the slot just read
  always_comb begin
    finish     = 1'b0;
    res_status = lpht_pkg::STATUS_MISSING;
    res_value  = '0;
    if (action == lpht_pkg::ACT_INSERT) begin
      if (!ram_rdata.valid) begin
        finish     = 1'b1;
        res_status = lpht_pkg::STATUS_INSERTED;
      end else if (wrapped) begin
        finish     = 1'b1;
        res_status = lpht_pkg::STATUS_FULL;
      end
    end else begin
      if (!ram_rdata.valid) begin
        // empty slot ends the chain
        finish     = 1'b1;
        res_status = lpht_pkg::STATUS_MISSING;
      end else if (hit) begin
        finish     = 1'b1;
        res_status = lpht_pkg::STATUS_FOUND;
        res_value  = ram_rdata.value;
      end else if (wrapped) begin
        finish     = 1'b1;
        res_status = lpht_pkg::STATUS_MISSING;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lpht_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = lpht_pkg::ST_IDLE;
        end
      end
      lpht_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = lpht_pkg::ST_READ;
        end
      end
      lpht_pkg::ST_READ: begin
        state_next = lpht_pkg::ST_CHECK;
      end
      lpht_pkg::ST_CHECK: begin
        if (!finish) begin
          state_next = lpht_pkg::ST_READ;
        end else if (out_free) begin
          state_next = lpht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpht_pkg::ST_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = '{valid: 1'b1, key: key, value: value};
    ram_re    = 1'b0;
    load_out  = 1'b0;
    case (state)
      lpht_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '{valid: 1'b0, key: '0, value: '0};
      end
      lpht_pkg::ST_IDLE: begin
        req.ready = 1'b1;
      end
      lpht_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      lpht_pkg::ST_CHECK: begin
        // hold the outcome while the output register is still occupied
        if (finish && out_free) begin
          load_out = 1'b1;
          ram_we   = (action == lpht_pkg::ACT_INSERT) && !ram_rdata.valid;
        end
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpht_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == lpht_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + {{(TABLE_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  // request capture and probe pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      action <= req.action;
      key    <= req.key;
      value  <= req.value;
      home   <= req.key[TABLE_BITS-1:0];
      pos    <= req.key[TABLE_BITS-1:0];
    end else if (state == lpht_pkg::ST_CHECK && !finish) begin
      pos <= pos_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status      <= res_status;
      rsp.found_value <= res_value;
    end
  end

endmodule
